// ===== sv/erdc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erdc_pkg
// Shared types and constants for the event ring dequeue classifier.
// ----------------------------------------------------------------------------
package erdc_pkg;

   // ring geometry limits
   localparam int unsigned MaxSegments          = 8;
   localparam int unsigned MaxEntriesPerSegment = 256;

   // event type codes
   localparam logic [5:0] TypeTransfer   = 6'd32;
   localparam logic [5:0] TypeCmdDone    = 6'd33;
   localparam logic [5:0] TypePortChange = 6'd34;
   localparam logic [5:0] TypeUnimplLo   = 6'd35;
   localparam logic [5:0] TypeUnimplHi   = 6'd39;

   localparam logic [7:0] CcSuccess = 8'd1;

   // configuration register indexes
   localparam logic [1:0] CsrEntriesPerSegment = 2'd0;
   localparam logic [1:0] CsrSegmentCount      = 2'd1;
   localparam logic [1:0] CsrPortCount         = 2'd2;

   typedef enum logic [2:0] {
      CLASS_NONE        = 3'd0,
      CLASS_PORT_CHANGE = 3'd1,
      CLASS_CMD_DONE    = 3'd2,
      CLASS_TRANSFER    = 3'd3,
      CLASS_UNIMPL      = 3'd4,
      CLASS_INVALID     = 3'd5
   } event_class_type;

   typedef enum logic [1:0] {
      OUTCOME_OK      = 2'd0,
      OUTCOME_INVALID = 2'd1,
      OUTCOME_UNIMPL  = 2'd2
   } outcome_type;

   // decoded view of one consumed entry
   typedef struct packed {
      event_class_type event_class;
      outcome_type     outcome;
      logic [7:0]      completion_code;
      logic [5:0]      event_type;
      logic [7:0]      port_index;
      logic [7:0]      slot_number;
   } entry_info_type;

endpackage

// ===== sv/erdc_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erdc_classify
// Decodes one event entry into class, outcome and the reported id fields.
// ----------------------------------------------------------------------------
module erdc_classify (
   input  logic [31:0]             param_low,
   input  logic [31:0]             status_word,
   input  logic [31:0]             control_word,
   input  logic [7:0]              port_count,
   output erdc_pkg::entry_info_type info
);
   import erdc_pkg::*;

   logic [7:0] cc;
   logic [5:0] ev_type;
   logic [7:0] port_idx;
   logic [7:0] slot;

   assign cc       = status_word[31:24];
   assign ev_type  = control_word[15:10];
   // port numbers are one-based, wraps on zero
   assign port_idx = param_low[31:24] - 8'd1;
   assign slot     = control_word[31:24];

   always_comb begin
      info                 = '0;
      info.completion_code = cc;
      info.event_type      = ev_type;
      if (ev_type == TypePortChange) begin
         info.event_class = CLASS_PORT_CHANGE;
         info.port_index  = port_idx;
         info.outcome     = (cc != CcSuccess || port_idx >= port_count)
                            ? OUTCOME_INVALID : OUTCOME_OK;
      end else if (ev_type == TypeCmdDone) begin
         info.event_class = CLASS_CMD_DONE;
         info.outcome     = OUTCOME_OK;
      end else if (ev_type == TypeTransfer) begin
         info.event_class = CLASS_TRANSFER;
         info.slot_number = slot;
         // slot zero names no device
         info.outcome     = (slot == 8'd0) ? OUTCOME_INVALID : OUTCOME_OK;
      end else if (ev_type >= TypeUnimplLo && ev_type <= TypeUnimplHi) begin
         info.event_class = CLASS_UNIMPL;
         info.outcome     = OUTCOME_UNIMPL;
      end else begin
         info.event_class = CLASS_INVALID;
         info.outcome     = OUTCOME_INVALID;
      end
   end

endmodule

// ===== sv/event_ring_dequeue_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_ring_dequeue_classifier
// Consumes event ring entries whose cycle bit matches, classifies them and
// advances the dequeue position; flags a pointer write-back at run end.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/stall    | param_low, status_word, control_word
//  rsp     | out       | rsp_valid/stall    | consumed .. write_back, one per req
//  csr     | in        | csr_write          | csr_index, csr_wdata (9 bits)
//
//  response beat registered from the request beat, one beat accepted per cycle while req_stall is low
//  the response is held in the single output register behind the decode logic
//  req_stall is high only while a response beat is held and rsp_stall is high
//  reset clears position to segment 0 index 0, cycle state 1, no output beat
//  registers reset to 256 entries, 1 segment, 0 ports
// ----------------------------------------------------------------------------
module event_ring_dequeue_classifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_param_low,
   input  logic [31:0] req_status_word,
   input  logic [31:0] req_control_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_consumed,
   output logic [2:0]  rsp_event_class,
   output logic [1:0]  rsp_outcome,
   output logic [7:0]  rsp_completion_code,
   output logic [5:0]  rsp_event_type,
   output logic [7:0]  rsp_port_index,
   output logic [7:0]  rsp_slot_number,
   output logic [2:0]  rsp_next_segment,
   output logic [7:0]  rsp_next_index,
   output logic        rsp_write_back,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata
);
   import erdc_pkg::*;

   localparam int unsigned EntryLimit =
      (MaxEntriesPerSegment > 256) ? 256 : MaxEntriesPerSegment;
   localparam logic [8:0] EntryLimitW = 9'(EntryLimit);
   localparam logic [3:0] SegLimitW   = 4'(MaxSegments);

   // configuration
   logic [8:0] entries_ff;
   logic [3:0] segments_ff;
   logic [7:0] ports_ff;

   // dequeue state
   logic [2:0] deq_segment_ff, deq_segment_in;
   logic [7:0] deq_index_ff, deq_index_in;
   logic       cycle_ff, cycle_in;
   logic       any_consumed_ff, any_consumed_in;

   // output register
   logic           rsp_valid_ff;
   logic           consumed_ff;
   entry_info_type info_ff;
   logic [2:0]     next_segment_ff;
   logic [7:0]     next_index_ff;
   logic           write_back_ff;

   logic           accept;
   logic           match;
   entry_info_type info;
   logic [8:0]     eff_entries;
   logic [3:0]     eff_segments;
   logic [8:0]     idx_inc;
   logic [3:0]     seg_inc;

   erdc_classify u_classify (
      .param_low    (req_param_low),
      .status_word  (req_status_word),
      .control_word (req_control_word),
      .port_count   (ports_ff),
      .info         (info)
   );

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign match     = (req_control_word[0] == cycle_ff);

   always_comb begin
      eff_entries = entries_ff;
      if (eff_entries == 9'd0) eff_entries = 9'd1;
      if (eff_entries > EntryLimitW) eff_entries = EntryLimitW;
      eff_segments = segments_ff;
      if (eff_segments == 4'd0) eff_segments = 4'd1;
      if (eff_segments > SegLimitW) eff_segments = SegLimitW;
   end

   assign idx_inc = {1'b0, deq_index_ff} + 9'd1;
   assign seg_inc = {1'b0, deq_segment_ff} + 4'd1;

   always_comb begin
      deq_index_in    = deq_index_ff;
      deq_segment_in  = deq_segment_ff;
      cycle_in        = cycle_ff;
      any_consumed_in = any_consumed_ff;
      if (match) begin
         any_consumed_in = 1'b1;
         // end tests use >= so a lowered bound wraps at once
         if (idx_inc >= eff_entries) begin
            deq_index_in = 8'd0;
            if (seg_inc >= eff_segments) begin
               deq_segment_in = 3'd0;
               cycle_in       = ~cycle_ff;
            end else begin
               deq_segment_in = seg_inc[2:0];
            end
         end else begin
            deq_index_in = idx_inc[7:0];
         end
      end else begin
         any_consumed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff      <= 9'd256;
         segments_ff     <= 4'd1;
         ports_ff        <= 8'd0;
         deq_segment_ff  <= 3'd0;
         deq_index_ff    <= 8'd0;
         cycle_ff        <= 1'b1;
         any_consumed_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CsrEntriesPerSegment: entries_ff  <= csr_wdata;
               CsrSegmentCount:      segments_ff <= csr_wdata[3:0];
               CsrPortCount:         ports_ff    <= csr_wdata[7:0];
               default: ;
            endcase
         end
         if (accept) begin
            deq_segment_ff  <= deq_segment_in;
            deq_index_ff    <= deq_index_in;
            cycle_ff        <= cycle_in;
            any_consumed_ff <= any_consumed_in;
            rsp_valid_ff    <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload, loaded with each accepted beat
   always_ff @(posedge clock) begin
      if (accept) begin
         consumed_ff     <= match;
         info_ff         <= match ? info : '0;
         next_segment_ff <= deq_segment_in;
         next_index_ff   <= deq_index_in;
         write_back_ff   <= !match && any_consumed_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_consumed        = consumed_ff;
   assign rsp_event_class     = info_ff.event_class;
   assign rsp_outcome         = info_ff.outcome;
   assign rsp_completion_code = info_ff.completion_code;
   assign rsp_event_type      = info_ff.event_type;
   assign rsp_port_index      = info_ff.port_index;
   assign rsp_slot_number     = info_ff.slot_number;
   assign rsp_next_segment    = next_segment_ff;
   assign rsp_next_index      = next_index_ff;
   assign rsp_write_back      = write_back_ff;

   a_wb_not_consumed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(write_back_ff && consumed_ff))
      else $error("write-back flagged on a consumed entry");

   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !consumed_ff |->
         info_ff.event_class == CLASS_NONE && info_ff.outcome == OUTCOME_OK)
      else $error("unconsumed entry reported with a class");

   a_miss_holds_pos: assert property (@(posedge clock) disable iff (reset)
      accept && !match |=> $stable(deq_index_ff) && $stable(deq_segment_ff)
         && $stable(cycle_ff) && !any_consumed_ff)
      else $error("dequeue position moved on a cycle bit mismatch");

   a_hit_sets_run: assert property (@(posedge clock) disable iff (reset)
      accept && match |=> any_consumed_ff && rsp_valid_ff && consumed_ff)
      else $error("consumed entry not recorded");

endmodule
